[hw/rtl/fdl_pkg.sv]
// Shared constants for the fractional delay line with feedback.
// Used by the channel interfaces and by the top, front and back RTL modules.
package fdl_pkg;

   // Field widths
   localparam int SAMPLE_W = 24;
   localparam int DELAY_W  = 20;
   localparam int GAIN_W   = 16;
   localparam int FRAC_W   = 8;

   // Blend only when the fraction is at least this many 1/256 steps
   localparam logic [FRAC_W-1:0] MIN_FRAC = 8'd3;

   // Rounding offsets for the blend (Q8) and the feedback (Q15)
   localparam int BLEND_RND = 128;
   localparam int FBK_RND   = 16384;
   localparam int FBK_SHIFT = 15;

   // Saturation limits of a stored sample
   localparam int SAMPLE_MAX = 8388607;
   localparam int SAMPLE_MIN = -8388608;

endpackage

[hw/rtl/fdl_req_if.sv]
// Input channel of the delay line: one audio word with its delay.
// Depends on fdl_pkg for the field widths.
interface fdl_req_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [fdl_pkg::SAMPLE_W-1:0]  sample_in;
   logic        [fdl_pkg::DELAY_W-1:0]   delay_q8;

   modport source (output valid, sample_in, delay_q8, input ready);
   modport sink   (input valid, sample_in, delay_q8, output ready);
endinterface

[hw/rtl/fdl_rsp_if.sv]
// Result channel of the delay line: one delayed, interpolated word.
// Depends on fdl_pkg for the field width.
interface fdl_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [fdl_pkg::SAMPLE_W-1:0]  sample_out;

   modport source (output valid, sample_out, input ready);
   modport sink   (input valid, sample_out, output ready);
endinterface

[hw/rtl/fdl_csr_if.sv]
// Configuration write channel: carries the feedback gain word.
// Depends on fdl_pkg for the field width.
interface fdl_csr_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [fdl_pkg::GAIN_W-1:0]    data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

[hw/rtl/fractional_delay_line_feedback_top.sv]
// Top level of the fractional delay line with linear interpolation and feedback.
// Depends on fdl_pkg, the three channel interfaces, fdl_front, fdl_queue, fdl_back.
//
// Usage:
//   req_if carries one word per audio sample: sample_in and delay_q8 (delay in
//   samples, 8 fraction bits, clamped to 1 .. DEPTH-1). rsp_if returns one
//   sample_out word per request, in order. csr_if writes feedback_gain (Q1.15);
//   it is always ready and should be written only while the block is idle.
//   Path: a request passes the front stage and the queue, then a 7-state
//   back-end sequence before rsp_if.valid. The back end takes a new word only
//   after its sequence returns to idle, since the sequencer reads both taps
//   through the single read port of the delay memory and runs two multiplies
//   in turn.
//   Reset: the write position returns to zero and the line reads as silence;
//   taps not yet written since reset are forced to zero, so no clearing pass.
//   Receiver stall: the result sits in the output register; the front stage
//   and the two-entry queue keep taking requests until they fill, then
//   req_if.ready drops.
module fractional_delay_line_feedback_top #(
   parameter int DEPTH = 4096
) (
   input  logic      clock,
   input  logic      reset,
   fdl_req_if.sink   req_if,
   fdl_rsp_if.source rsp_if,
   fdl_csr_if.sink   csr_if
);

   localparam int AW   = $clog2(DEPTH);
   localparam int OP_W = fdl_pkg::SAMPLE_W + 3 * AW + fdl_pkg::FRAC_W + 2;

   logic                               f_valid, f_ready;
   logic [OP_W-1:0]                    f_data;
   logic                               b_valid, b_ready;
   logic [OP_W-1:0]                    b_data;
   logic signed [fdl_pkg::GAIN_W-1:0]  gain_ff, gain_in;

   // Feedback gain register
   assign csr_if.ready = 1'b1;
   assign gain_in      = (csr_if.valid && csr_if.ready) ? csr_if.data : gain_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff <= '0;
      end else begin
         gain_ff <= gain_in;
      end
   end

   fdl_front #(
      .DEPTH (DEPTH),
      .AW    (AW),
      .OP_W  (OP_W)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .req_if   (req_if),
      .op_valid (f_valid),
      .op_ready (f_ready),
      .op_data  (f_data)
   );

   fdl_queue #(
      .W (OP_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (f_valid),
      .in_ready  (f_ready),
      .in_data   (f_data),
      .out_valid (b_valid),
      .out_ready (b_ready),
      .out_data  (b_data)
   );

   fdl_back #(
      .DEPTH (DEPTH),
      .AW    (AW),
      .OP_W  (OP_W)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .op_valid (b_valid),
      .op_ready (b_ready),
      .op_data  (b_data),
      .gain     (gain_ff),
      .rsp_if   (rsp_if)
   );

endmodule

[hw/rtl/fdl_front.sv]
// Front end: accepts words, clamps the delay, works out the read taps.
// Depends on fdl_pkg and fdl_req_if; feeds fdl_queue.
module fdl_front #(
   parameter int DEPTH = 4096,
   parameter int AW    = 12,
   parameter int OP_W  = 62
) (
   input  logic            clock,
   input  logic            reset,
   fdl_req_if.sink         req_if,
   output logic            op_valid,
   input  logic            op_ready,
   output logic [OP_W-1:0] op_data
);

   localparam int SW = (AW + 10 > fdl_pkg::DELAY_W + 1) ? AW + 10 : fdl_pkg::DELAY_W + 1;
   localparam logic [SW-1:0] SPAN = SW'(DEPTH) << 8;
   localparam logic [SW-1:0] DMAX = SW'(DEPTH - 1) << 8;
   localparam logic [SW-1:0] DMIN = SW'(256);
   localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

   typedef struct packed {
      logic signed [fdl_pkg::SAMPLE_W-1:0] x;
      logic [AW-1:0]                       wp;
      logic [AW-1:0]                       lo;
      logic [AW-1:0]                       hi;
      logic [fdl_pkg::FRAC_W-1:0]          f;
      logic                                lo_ok;
      logic                                hi_ok;
   } op_type;

   logic                                 accept;
   logic                                 s_valid_ff, s_valid_in;
   logic signed [fdl_pkg::SAMPLE_W-1:0]  s_x_ff;
   logic [SW-1:0]                        s_d_ff, d_ext, d_cl;
   logic [AW-1:0]                        s_wp_ff, wp_ff, wp_in;
   logic                                 s_wrap_ff, wrap_ff, wrap_in;
   logic [SW-1:0]                        pos_sum, pos;
   logic [AW-1:0]                        lo, hi;
   logic [fdl_pkg::FRAC_W-1:0]           frac;
   logic                                 blend;
   op_type                               op;

   assign req_if.ready = !s_valid_ff || op_ready;
   assign accept       = req_if.valid && req_if.ready;

   // Delay clamp to one sample .. DEPTH-1 samples
   assign d_ext = SW'(req_if.delay_q8);
   assign d_cl  = (d_ext < DMIN) ? DMIN : ((d_ext > DMAX) ? DMAX : d_ext);

   // Write position counter, one step per accepted word
   always_comb begin
      wp_in   = wp_ff;
      wrap_in = wrap_ff;
      if (accept) begin
         if (wp_ff == LAST) begin
            wp_in   = '0;
            wrap_in = 1'b1;
         end else begin
            wp_in = wp_ff + AW'(1);
         end
      end
   end

   assign s_valid_in = accept ? 1'b1 : (op_ready ? 1'b0 : s_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s_valid_ff <= 1'b0;
         wp_ff      <= '0;
         wrap_ff    <= 1'b0;
      end else begin
         s_valid_ff <= s_valid_in;
         wp_ff      <= wp_in;
         wrap_ff    <= wrap_in;
      end
   end

   // Stage payload
   always_ff @(posedge clock) begin
      if (accept) begin
         s_x_ff    <= req_if.sample_in;
         s_d_ff    <= d_cl;
         s_wp_ff   <= wp_ff;
         s_wrap_ff <= wrap_ff;
      end
   end

   // Read position in Q8, modulo the span
   always_comb begin
      pos_sum = SW'({s_wp_ff, 8'h00}) + SPAN - s_d_ff;
      pos     = (pos_sum >= SPAN) ? pos_sum - SPAN : pos_sum;
      lo      = pos[AW+7:8];
      frac    = pos[7:0];
      hi      = (lo == LAST) ? '0 : lo + AW'(1);
      blend   = (frac >= fdl_pkg::MIN_FRAC) && (s_d_ff > DMIN);
   end

   // Entries not yet written since reset read as zero
   always_comb begin
      op.x     = s_x_ff;
      op.wp    = s_wp_ff;
      op.lo    = lo;
      op.hi    = hi;
      op.f     = blend ? frac : '0;
      op.lo_ok = s_wrap_ff || (lo < s_wp_ff);
      op.hi_ok = s_wrap_ff || (hi < s_wp_ff);
   end

   assign op_valid = s_valid_ff;
   assign op_data  = op;

endmodule

[hw/rtl/fdl_queue.sv]
// Two-entry queue between the front end and the back end.
// Depends on nothing but its width parameter.
module fdl_queue #(
   parameter int W = 62
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   output logic         in_ready,
   input  logic [W-1:0] in_data,
   output logic         out_valid,
   input  logic         out_ready,
   output logic [W-1:0] out_data
);

   logic [W-1:0] data_ff [2];
   logic         wr_ptr_ff, wr_ptr_in;
   logic         rd_ptr_ff, rd_ptr_in;
   logic [1:0]   count_ff, count_in;
   logic         push, pop;

   assign in_ready  = (count_ff != 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign out_data  = data_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   // Pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         data_ff[wr_ptr_ff] <= in_data;
      end
   end

endmodule

[hw/rtl/fdl_back.sv]
// Back end: reads the two taps, blends, applies feedback, writes the line.
// Depends on fdl_pkg and fdl_rsp_if; fed by fdl_queue.
module fdl_back #(
   parameter int DEPTH = 4096,
   parameter int AW    = 12,
   parameter int OP_W  = 62
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               op_valid,
   output logic                               op_ready,
   input  logic [OP_W-1:0]                    op_data,
   input  logic signed [fdl_pkg::GAIN_W-1:0]  gain,
   fdl_rsp_if.source                          rsp_if
);

   localparam int SMPW = fdl_pkg::SAMPLE_W;

   typedef struct packed {
      logic signed [SMPW-1:0]     x;
      logic [AW-1:0]              wp;
      logic [AW-1:0]              lo;
      logic [AW-1:0]              hi;
      logic [fdl_pkg::FRAC_W-1:0] f;
      logic                       lo_ok;
      logic                       hi_ok;
   } op_type;

   typedef enum logic [6:0] {
      ST_IDLE = 7'b0000001,
      ST_RDLO = 7'b0000010,
      ST_RDHI = 7'b0000100,
      ST_MUL  = 7'b0001000,
      ST_Y    = 7'b0010000,
      ST_FBK  = 7'b0100000,
      ST_SAT  = 7'b1000000
   } state_type;

   state_type               state_ff, state_in;
   op_type                  op_ff;
   logic signed [SMPW-1:0]  mem [DEPTH];
   logic signed [SMPW-1:0]  rd_ff;
   logic [AW-1:0]           raddr;
   logic                    we;
   logic signed [SMPW-1:0]  v0_ff, v1;
   logic signed [SMPW:0]    diff;
   logic signed [33:0]      prod_ff, prod_c;
   logic signed [34:0]      ysum;
   logic signed [SMPW-1:0]  y_ff;
   logic signed [39:0]      fbprod_ff;
   logic signed [40:0]      fbk_sum;
   logic signed [25:0]      fbk;
   logic signed [26:0]      save;
   logic signed [SMPW-1:0]  save_sat;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic signed [SMPW-1:0]  rsp_data_ff;
   logic                    out_free, load_out;

   assign out_free = !rsp_valid_ff || rsp_if.ready;
   assign op_ready = (state_ff == ST_IDLE);

   // Sequencer: one memory port, so taps are read one after the other
   always_comb begin
      state_in = state_ff;
      load_out = 1'b0;
      case (state_ff)
         ST_IDLE: if (op_valid) state_in = ST_RDLO;
         ST_RDLO: state_in = ST_RDHI;
         ST_RDHI: state_in = ST_MUL;
         ST_MUL:  state_in = ST_Y;
         ST_Y:    state_in = ST_FBK;
         ST_FBK:  state_in = ST_SAT;
         ST_SAT: begin
            if (out_free) begin
               load_out = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Delay memory: write the saturated word once, read one tap a cycle
   assign raddr = (state_ff == ST_RDLO) ? op_ff.lo : op_ff.hi;
   assign we    = load_out;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[op_ff.wp] <= save_sat;
      end
      rd_ff <= mem[raddr];
   end

   // Datapath arithmetic
   always_comb begin
      v1      = op_ff.hi_ok ? rd_ff : '0;
      diff    = {v1[SMPW-1], v1} - {v0_ff[SMPW-1], v0_ff};
      prod_c  = diff * $signed({1'b0, op_ff.f});
      ysum    = $signed({{3{v0_ff[SMPW-1]}}, v0_ff, 8'h00}) + 35'(prod_ff)
                + 35'(fdl_pkg::BLEND_RND);
      fbk_sum = 41'(fbprod_ff) + 41'(fdl_pkg::FBK_RND);
      fbk     = fbk_sum[40:fdl_pkg::FBK_SHIFT];
      save    = 27'(op_ff.x) + 27'(fbk);
      if (save > 27'(fdl_pkg::SAMPLE_MAX)) begin
         save_sat = SMPW'(fdl_pkg::SAMPLE_MAX);
      end else if (save < 27'(fdl_pkg::SAMPLE_MIN)) begin
         save_sat = SMPW'(fdl_pkg::SAMPLE_MIN);
      end else begin
         save_sat = save[SMPW-1:0];
      end
   end

   // Datapath registers, one operation per state
   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && op_valid) begin
         op_ff <= op_type'(op_data);
      end
      if (state_ff == ST_RDHI) begin
         v0_ff <= op_ff.lo_ok ? rd_ff : '0;
      end
      if (state_ff == ST_MUL) begin
         prod_ff <= prod_c;
      end
      if (state_ff == ST_Y) begin
         y_ff <= ysum[SMPW+7:8];
      end
      if (state_ff == ST_FBK) begin
         fbprod_ff <= y_ff * gain;
      end
      if (load_out) begin
         rsp_data_ff <= y_ff;
      end
   end

   // Output word register
   assign rsp_valid_in = load_out ? 1'b1 : (rsp_if.ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.sample_out = rsp_data_ff;

endmodule

[tb/fractional_delay_line_feedback_top_tb.sv]
`timescale 1ns / 100ps
// Testbench for the fractional delay line with feedback: a bursty driver, a stalling
// receiver and an in-order checker against a cycle-free model of the delay line.
// Depends on fdl_pkg, the three fdl channel interfaces and fractional_delay_line_feedback_top.
module fractional_delay_line_feedback_top_tb;

   localparam int LINE_DEPTH = 4096;
   localparam int SMPW       = fdl_pkg::SAMPLE_W;

   typedef struct packed {
      logic signed [fdl_pkg::SAMPLE_W-1:0] sample;
      logic        [fdl_pkg::DELAY_W-1:0]  delay;
   } audio_word_type;

   typedef enum logic [1:0] {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_COMB} rx_mode_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   fdl_req_if req_ch ();
   fdl_rsp_if rsp_ch ();
   fdl_csr_if csr_ch ();

   fractional_delay_line_feedback_top #(
      .DEPTH (LINE_DEPTH)
   ) u_top (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch),
      .csr_if (csr_ch)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Model state: line contents, write pointer, feedback gain
   logic signed [SMPW-1:0]             line_mem [LINE_DEPTH];
   int unsigned                        wr_pos;
   logic signed [fdl_pkg::GAIN_W-1:0]  fbk_gain;

   audio_word_type                     sample_feed_q [$];
   logic signed [SMPW-1:0]             tap_out_q [$];
   int                                 queued_total   = 0;
   int                                 accepted_total = 0;
   int                                 mismatch_count = 0;

   audio_word_type                     next_word;
   logic signed [SMPW-1:0]             want_tap;
   int                                 burst_left;
   int                                 gap_left;
   rx_mode_type                        rx_mode;
   int                                 rx_left;
   int unsigned                        rx_phase;
   logic                               rx_open;
   logic                               hold_rsp = 1'b0;

   // One word through the line: returns the tap, stores input plus feedback
   function automatic logic signed [SMPW-1:0] interp_tap(
      input logic signed [SMPW-1:0]              word_in,
      input logic        [fdl_pkg::DELAY_W-1:0]  delay_req
   );
      int unsigned d;
      int unsigned pos;
      int unsigned lo;
      int unsigned f;
      longint      tap0;
      longint      tap1;
      longint      tap;
      longint      fbk;
      longint      save;
      d = delay_req;
      if (d < 256) d = 256;
      if (d > (LINE_DEPTH - 1) * 256) d = (LINE_DEPTH - 1) * 256;
      pos  = (wr_pos * 256 + LINE_DEPTH * 256 - d) % (LINE_DEPTH * 256);
      lo   = pos >> fdl_pkg::FRAC_W;
      f    = pos & 255;
      tap0 = line_mem[lo];
      tap  = tap0;
      // blend only for a real fraction and more than one sample of delay
      if (f >= fdl_pkg::MIN_FRAC && d > 256) begin
         tap1 = line_mem[(lo + 1) % LINE_DEPTH];
         tap  = (tap1 * longint'(f) + tap0 * longint'(256 - f) + fdl_pkg::BLEND_RND)
                >>> fdl_pkg::FRAC_W;
      end
      fbk  = (tap * longint'(fbk_gain) + fdl_pkg::FBK_RND) >>> fdl_pkg::FBK_SHIFT;
      save = longint'(word_in) + fbk;
      if (save > fdl_pkg::SAMPLE_MAX) save = fdl_pkg::SAMPLE_MAX;
      if (save < fdl_pkg::SAMPLE_MIN) save = fdl_pkg::SAMPLE_MIN;
      line_mem[wr_pos] = save[SMPW-1:0];
      wr_pos = (wr_pos + 1) % LINE_DEPTH;
      return tap[SMPW-1:0];
   endfunction

   task automatic queue_word(input int s, input int unsigned d);
      audio_word_type w;
      w.sample = s[SMPW-1:0];
      w.delay  = d[fdl_pkg::DELAY_W-1:0];
      sample_feed_q.push_back(w);
      queued_total++;
   endtask

   // Wait at falling edges until every queued word is accepted and answered
   task automatic wait_drained();
      do @(negedge clock);
      while (accepted_total != queued_total || tap_out_q.size() != 0);
   endtask

   task automatic write_gain(input logic signed [fdl_pkg::GAIN_W-1:0] g);
      @(posedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.data  <= g;
      do @(posedge clock);
      while (!csr_ch.ready);
      csr_ch.valid <= 1'b0;
      fbk_gain = g;
      @(negedge clock);
   endtask

   task automatic feed_random(input int count);
      logic signed [SMPW-1:0] s;
      int unsigned            d;
      int unsigned            k;
      for (int i = 0; i < count; i++) begin
         // mostly random samples, some full-scale and near-zero
         if ($urandom_range(0, 99) < 15) begin
            case ($urandom_range(0, 3))
               0:       s = SMPW'(fdl_pkg::SAMPLE_MAX);
               1:       s = SMPW'(fdl_pkg::SAMPLE_MIN);
               2:       s = '0;
               default: s = '1;
            endcase
         end else begin
            s = SMPW'($urandom);
         end
         // delays: short taps, fraction edges, anything, clamp edges, long taps
         k = $urandom_range(0, 99);
         if (k < 45) begin
            d = $urandom_range(0, 40 * 256);
         end else if (k < 65) begin
            d = $urandom_range(1, 60) * 256 + $urandom_range(0, 4) - 2;
         end else if (k < 80) begin
            d = $urandom & 32'hFFFFF;
         end else if (k < 90) begin
            d = ($urandom_range(0, 1) != 0) ? $urandom_range(1048256, 1048575)
                                           : $urandom_range(0, 300);
         end else begin
            d = $urandom_range(0, 1300 * 256);
         end
         queue_word(int'(s), d);
      end
   endtask

   // Sender: bursts of words with random gaps
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid     <= 1'b0;
         req_ch.sample_in <= '0;
         req_ch.delay_q8  <= '0;
         burst_left = 0;
         gap_left   = 0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            tap_out_q.push_back(interp_tap(req_ch.sample_in, req_ch.delay_q8));
            accepted_total++;
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_ch.valid <= 1'b0;
            end else if (sample_feed_q.size() != 0) begin
               next_word = sample_feed_q.pop_front();
               req_ch.valid     <= 1'b1;
               req_ch.sample_in <= next_word.sample;
               req_ch.delay_q8  <= next_word.delay;
               if (burst_left > 0) begin
                  burst_left--;
               end else if ($urandom_range(0, 3) == 0) begin
                  // long stretch with no idling
                  burst_left = $urandom_range(40, 80);
                  gap_left   = 0;
               end else begin
                  burst_left = $urandom_range(0, 12);
                  gap_left   = $urandom_range(0, 15);
               end
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // Receiver: picks a new stall pattern at random whenever its current one runs out
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         rx_mode  = RX_OPEN;
         rx_left  = 0;
         rx_phase = 0;
      end else begin
         if (rx_left == 0) begin
            rx_mode = rx_mode_type'($urandom_range(0, 3));
            rx_left = $urandom_range(100, 400);
         end else begin
            rx_left--;
         end
         rx_phase++;
         case (rx_mode)
            RX_OPEN:  rx_open = 1'b1;
            RX_LIGHT: rx_open = ($urandom_range(0, 3) != 0);
            RX_HEAVY: rx_open = ($urandom_range(0, 9) < 3);
            default:  rx_open = (rx_phase[2:0] < 3);
         endcase
         rsp_ch.ready <= rx_open && !hold_rsp;
      end
   end

   // Long receiver hold-offs so the block backs up and drops req ready
   initial begin
      wait (accepted_total >= 300);
      @(posedge clock);
      hold_rsp <= 1'b1;
      repeat (400) @(posedge clock);
      hold_rsp <= 1'b0;
      wait (accepted_total >= 900);
      @(posedge clock);
      hold_rsp <= 1'b1;
      repeat (250) @(posedge clock);
      hold_rsp <= 1'b0;
   end

   // Checker: every result against the oldest expected tap
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (tap_out_q.size() == 0) begin
            if (mismatch_count < 10)
               $display("unexpected word: sample_out=%0d", rsp_ch.sample_out);
            mismatch_count++;
         end else begin
            want_tap = tap_out_q.pop_front();
            if (rsp_ch.sample_out !== want_tap) begin
               if (mismatch_count < 10)
                  $display("sample_out mismatch: expected %0d, got %0d",
                           want_tap, rsp_ch.sample_out);
               mismatch_count++;
            end
         end
      end
   end

   initial begin
      #5_000_000;
      $display("FAILURE");
      $finish;
   end

   initial begin
      logic signed [fdl_pkg::GAIN_W-1:0] g;
      csr_ch.valid     <= 1'b0;
      csr_ch.data      <= '0;
      foreach (line_mem[i]) line_mem[i] = '0;
      wr_pos   = 0;
      fbk_gain = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed words at full positive feedback
      write_gain(16'sh7FFF);
      queue_word(fdl_pkg::SAMPLE_MAX, 0);       // delay below one sample, clamped
      queue_word(fdl_pkg::SAMPLE_MAX, 256);     // one-sample tap, positive saturation
      queue_word(fdl_pkg::SAMPLE_MIN, 255);     // clamped up to one sample
      queue_word(fdl_pkg::SAMPLE_MIN, 256);     // negative saturation
      queue_word(fdl_pkg::SAMPLE_MIN, 256);
      queue_word(0, 257);                       // fraction 255, blended
      queue_word(-1, 258);                      // fraction 254
      queue_word(1, 510);                       // fraction 2: lower tap alone
      queue_word(123456, 509);                  // fraction 3: smallest blended fraction
      queue_word(-654321, 511);                 // fraction 1
      queue_word(4000000, 512);                 // whole delay
      queue_word(-4000000, 'hFFFFF);            // delay field all ones, clamped to max
      queue_word(fdl_pkg::SAMPLE_MAX, 1048320); // maximum delay exactly
      queue_word(fdl_pkg::SAMPLE_MIN, 1048319); // just below maximum, fraction 1
      queue_word(777, 1048064);
      queue_word(-777, queued_total * 256 + 100);   // upper tap wraps to entry 0
      queue_word(8191, queued_total * 256 + 1);
      queue_word(-8192, 768 + 37);
      queue_word(fdl_pkg::SAMPLE_MAX, 256 + 128);  // half-way blend, rounding
      queue_word(fdl_pkg::SAMPLE_MIN, 256 + 128);
      queue_word(2, 256 + 3);
      queue_word(-3, 256 + 253);
      wait_drained();

      // Random phases across gain settings, extremes included
      for (int ph = 0; ph < 6; ph++) begin
         repeat (12) @(posedge clock);
         case (ph)
            0:       g = 16'sh8000;
            1:       g = 16'sh0000;
            2:       g = 16'sh4000;
            3:       g = 16'shFFFF;
            4:       g = 16'sh7FFF;
            default: g = fdl_pkg::GAIN_W'($urandom);
         endcase
         write_gain(g);
         feed_random(205);
         wait_drained();
      end

      repeat (20) @(posedge clock);
      if (mismatch_count == 0 && tap_out_q.size() == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

[filelist.f]
hw/rtl/fdl_pkg.sv
hw/rtl/fdl_req_if.sv
hw/rtl/fdl_rsp_if.sv
hw/rtl/fdl_csr_if.sv
hw/rtl/fdl_front.sv
hw/rtl/fdl_queue.sv
hw/rtl/fdl_back.sv
hw/rtl/fractional_delay_line_feedback_top.sv
tb/fractional_delay_line_feedback_top_tb.sv
